@@ src/irsa_pkg.sv @@
`timescale 1ns / 1ps

package irsa_pkg;

  localparam int unsigned DataW         = 32;
  localparam int unsigned StackDepthDef = 64;
  localparam int unsigned DivStepW      = 6;

  typedef enum logic [1:0] {
    REQ_PUSH  = 2'd0,
    REQ_BINOP = 2'd1,
    REQ_CLEAR = 2'd2
  } req_e;

  typedef enum logic [3:0] {
    OP_ADD = 4'd0,
    OP_SUB = 4'd1,
    OP_MUL = 4'd2,
    OP_DIV = 4'd3,
    OP_MOD = 4'd4,
    OP_AND = 4'd5,
    OP_OR  = 4'd6,
    OP_XOR = 4'd7,
    OP_POW = 4'd8
  } op_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_DIVZERO = 2'd1,
    ST_UNDER   = 2'd2,
    ST_OVER    = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_MUL,
    S_DIV,
    S_WB,
    S_RESP
  } state_e;

  function automatic logic [DataW-1:0] abs_val(input logic [DataW-1:0] v);
    abs_val = v[DataW-1] ? (DataW'(0) - v) : v;
  endfunction

endpackage

@@ src/integer_rpn_stack_alu.sv @@
`timescale 1ns / 1ps

// Integer RPN stack calculator. Each request on the slave stream (push, binary
// operation or clear) gives exactly one response on the master stream carrying
// the status, the new top of stack (zero when empty) and the new depth. The
// operand stack lives in a single-port-write, single-port-read memory; the top
// entry is also held in a register, so an operation reads only the entry below
// it. Push, clear, an unassigned request type, overflow and underflow go
// straight to the response; a zero divisor is found in the execute state; add,
// sub, and, or, xor, an unassigned opcode and pow with a negative exponent go
// from execute to write-back; mul and pow run the square-and-multiply loop,
// which takes one step per exponent bit, and div and mod run the restoring
// divider that retires one quotient bit per cycle. The next request is accepted
// once the response has been placed in the output register.
module integer_rpn_stack_alu #(
  parameter int unsigned STACK_DEPTH = irsa_pkg::StackDepthDef,
  localparam int unsigned CntW      = $clog2(STACK_DEPTH + 1),
  localparam int unsigned OutDataW  = ((irsa_pkg::DataW + CntW + 7) / 8) * 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // push_value
  input  logic [irsa_pkg::DataW-1:0]    s_axis_tdata,
  // req_type [1:0], opcode [5:2]
  input  logic [5:0]                    s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // top_value, depth, zero padding
  output logic [OutDataW-1:0]           m_axis_tdata,
  // status
  output logic [1:0]                    m_axis_tuser
);

  import irsa_pkg::*;

  localparam int unsigned AddrW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  logic [DataW-1:0] stack_mem [STACK_DEPTH];

  state_e            state_q, state_d;
  logic [CntW-1:0]   count_q, count_d;
  logic [DataW-1:0]  top_q, top_d;
  status_e           status_q, status_d;
  op_e               op_q, op_d;
  logic [DataW-1:0]  rd_q;
  logic [DataW-1:0]  res_q, res_d;
  logic [DataW-1:0]  acc_q, acc_d;
  logic [DataW-1:0]  base_q, base_d;
  logic [DataW-1:0]  exp_q, exp_d;
  logic [DataW-1:0]  rem_q, rem_d;
  logic [DataW-1:0]  dq_q, dq_d;
  logic [DataW-1:0]  dsr_q, dsr_d;
  logic              neg_q_q, neg_q_d;
  logic              neg_r_q, neg_r_d;
  logic [DivStepW-1:0] iter_q, iter_d;
  logic              out_valid_q, out_valid_d;
  status_e           out_stat_q, out_stat_d;
  logic [DataW-1:0]  out_top_q, out_top_d;
  logic [CntW-1:0]   out_depth_q, out_depth_d;

  logic              in_accept;
  logic              out_free;
  req_e              in_req;
  op_e               in_op;
  logic [CntW-1:0]   cnt_m2;
  logic [AddrW-1:0]  rd_addr;
  logic              mem_we;
  logic [AddrW-1:0]  wr_addr;
  logic [DataW-1:0]  wr_data;
  logic [DataW:0]    div_shift;
  logic [DataW:0]    div_diff;
  logic [DataW-1:0]  opd_a;
  logic [DataW-1:0]  opd_b;

  assign in_req    = req_e'(s_axis_tuser[1:0]);
  assign in_op     = op_e'(s_axis_tuser[5:2]);
  assign in_accept = s_axis_tvalid && s_axis_tready;
  assign out_free  = !out_valid_q || m_axis_tready;
  assign cnt_m2    = count_q - CntW'(2);
  assign rd_addr   = cnt_m2[AddrW-1:0];
  assign opd_a     = rd_q;
  assign opd_b     = top_q;
  assign div_shift = {rem_q, dq_q[DataW-1]};
  assign div_diff  = div_shift - {1'b0, dsr_q};

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_stat_q;
  assign m_axis_tdata  = OutDataW'({out_depth_q, out_top_q});

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      stack_mem[wr_addr] <= wr_data;
    end
    rd_q <= stack_mem[rd_addr];
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          if (in_req == REQ_BINOP && count_q >= CntW'(2)) begin
            state_d = S_EXEC;
          end else begin
            state_d = S_RESP;
          end
        end
      end
      S_EXEC: begin
        unique case (op_q)
          OP_MUL: state_d = S_MUL;
          OP_POW: state_d = opd_b[DataW-1] ? S_WB : S_MUL;
          OP_DIV, OP_MOD: state_d = (opd_b == '0) ? S_RESP : S_DIV;
          default: state_d = S_WB;
        endcase
      end
      S_MUL: begin
        if (exp_q == '0) begin
          state_d = S_WB;
        end
      end
      S_DIV: begin
        if (iter_q[DivStepW-1]) begin
          state_d = S_WB;
        end
      end
      S_WB: state_d = S_RESP;
      S_RESP: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    count_d     = count_q;
    top_d       = top_q;
    status_d    = status_q;
    op_d        = op_q;
    res_d       = res_q;
    acc_d       = acc_q;
    base_d      = base_q;
    exp_d       = exp_q;
    rem_d       = rem_q;
    dq_d        = dq_q;
    dsr_d       = dsr_q;
    neg_q_d     = neg_q_q;
    neg_r_d     = neg_r_q;
    iter_d      = iter_q;
    out_stat_d  = out_stat_q;
    out_top_d   = out_top_q;
    out_depth_d = out_depth_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    mem_we      = 1'b0;
    wr_addr     = count_q[AddrW-1:0];
    wr_data     = s_axis_tdata;

    unique case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          op_d     = in_op;
          status_d = ST_OK;
          unique case (in_req)
            REQ_PUSH: begin
              if (count_q < CntW'(STACK_DEPTH)) begin
                mem_we  = 1'b1;
                count_d = count_q + CntW'(1);
                top_d   = s_axis_tdata;
              end else begin
                status_d = ST_OVER;
              end
            end
            REQ_BINOP: begin
              if (count_q < CntW'(2)) begin
                count_d  = '0;
                top_d    = '0;
                status_d = ST_UNDER;
              end
            end
            REQ_CLEAR: begin
              count_d = '0;
              top_d   = '0;
            end
            default: ;
          endcase
        end
      end
      S_EXEC: begin
        unique case (op_q)
          OP_ADD: res_d = opd_a + opd_b;
          OP_SUB: res_d = opd_a - opd_b;
          OP_AND: res_d = opd_a & opd_b;
          OP_OR:  res_d = opd_a | opd_b;
          OP_XOR: res_d = opd_a ^ opd_b;
          OP_MUL: begin
            acc_d  = opd_a;
            base_d = opd_b;
            exp_d  = DataW'(1);
          end
          OP_POW: begin
            if (opd_b[DataW-1]) begin
              if (opd_a == DataW'(1)) begin
                res_d = DataW'(1);
              end else if (opd_a == '1) begin
                res_d = opd_b[0] ? '1 : DataW'(1);
              end else begin
                res_d = '0;
              end
            end else begin
              acc_d  = DataW'(1);
              base_d = opd_a;
              exp_d  = opd_b;
            end
          end
          OP_DIV, OP_MOD: begin
            if (opd_b == '0) begin
              count_d  = '0;
              top_d    = '0;
              status_d = ST_DIVZERO;
            end else begin
              rem_d   = '0;
              dq_d    = abs_val(opd_a);
              dsr_d   = abs_val(opd_b);
              neg_q_d = opd_a[DataW-1] ^ opd_b[DataW-1];
              neg_r_d = opd_a[DataW-1];
              iter_d  = '0;
            end
          end
          default: res_d = opd_a;
        endcase
      end
      S_MUL: begin
        if (exp_q == '0) begin
          res_d = acc_q;
        end else begin
          if (exp_q[0]) begin
            acc_d = acc_q * base_q;
          end
          base_d = base_q * base_q;
          exp_d  = exp_q >> 1;
        end
      end
      S_DIV: begin
        if (iter_q[DivStepW-1]) begin
          if (op_q == OP_DIV) begin
            res_d = neg_q_q ? (DataW'(0) - dq_q) : dq_q;
          end else begin
            res_d = neg_r_q ? (DataW'(0) - rem_q) : rem_q;
          end
        end else begin
          if (!div_diff[DataW]) begin
            rem_d = div_diff[DataW-1:0];
          end else begin
            rem_d = div_shift[DataW-1:0];
          end
          dq_d   = {dq_q[DataW-2:0], !div_diff[DataW]};
          iter_d = iter_q + DivStepW'(1);
        end
      end
      S_WB: begin
        mem_we   = 1'b1;
        wr_addr  = rd_addr;
        wr_data  = res_q;
        count_d  = count_q - CntW'(1);
        top_d    = res_q;
        status_d = ST_OK;
      end
      S_RESP: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_stat_d  = status_q;
          out_top_d   = top_q;
          out_depth_d = count_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      top_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      top_q       <= top_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q    <= status_d;
    op_q        <= op_d;
    res_q       <= res_d;
    acc_q       <= acc_d;
    base_q      <= base_d;
    exp_q       <= exp_d;
    rem_q       <= rem_d;
    dq_q        <= dq_d;
    dsr_q       <= dsr_d;
    neg_q_q     <= neg_q_d;
    neg_r_q     <= neg_r_d;
    iter_q      <= iter_d;
    out_stat_q  <= out_stat_d;
    out_top_q   <= out_top_d;
    out_depth_q <= out_depth_d;
  end

endmodule
